[rtl/mpe_pkg.sv]
// shared types and constants for the matrix product engine
package mpe_pkg;

  localparam int unsigned DIM_W   = 7;   // width of the dimension registers
  localparam int unsigned IDX_W   = 6;   // width of row and column indexes
  localparam int unsigned ELEM_W  = 16;  // Q8.8 element
  localparam int unsigned PROD_W  = 32;  // Q16.16 single term
  localparam int unsigned ACC_W   = 38;  // Q22.16 accumulated sum
  localparam int unsigned CFG_A_W = 2;   // configuration register index

  typedef enum logic [1:0] {
    MODE_WR_A = 2'd0,
    MODE_WR_B = 2'd1,
    MODE_RD   = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_ROW   = 2'd0,
    REG_COL   = 2'd1,
    REG_INNER = 2'd2,
    REG_NONE  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT
  } state_t;

  // sideband that travels with each store read down the multiply-add pipe
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

[rtl/matrix_product_engine_top.sv]
// top level of the matrix product engine: control, stores and result register
//
// Computes one element of C = A x B per read request. The input stream carries
// the request kind on in_tuser (write A, write B, read product) and row, column
// and Q8.8 element on in_tdata. Every input beat gives exactly one result beat:
// the Q22.16 product on out_tdata (zero for writes and errors) and an error
// flag on out_tuser, set for MODE_NONE or an index outside the set dimensions.
// A and B live in two single-port rams of MAX_DIM*MAX_DIM entries each.
// A write's result is registered at the accepting edge. A read walks
// inner_count terms through one multiplier and accumulator, one ram read per
// cycle; each term passes the ram read, product and accumulator registers. One
// read is in flight at a time; writes stream one per cycle. A waiting result
// does not block the next beat as long as out_tready takes it in the same
// cycle; otherwise in_tready stays low until it is taken. Reset clears the
// handshake state and sets all three dimensions to 64 (or MAX_DIM if smaller);
// the ram contents are undefined until written. The user must write dimension
// registers through cfg_* while the engine is idle, unenforced by the block.
module matrix_product_engine_top #(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: row_index[5:0], col_index[11:6], element_value[27:12], zero pad
  input  logic [31:0]                 in_tdata,
  // in_tuser: mode[1:0]
  input  logic [1:0]                  in_tuser,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // out_tdata: product_value[37:0], zero pad
  output logic [39:0]                 out_tdata,
  // out_tuser: status[0]
  output logic                        out_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        cfg_we,
  input  logic [mpe_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [mpe_pkg::DIM_W-1:0]   cfg_wdata
);
  import mpe_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [DIM_W-1:0] RST_DIM = (MAX_DIM < 64) ? DIM_W'(MAX_DIM) : DIM_W'(64);

  // configuration
  logic [DIM_W-1:0] row_cnt_r, col_cnt_r, inner_cnt_r;
  logic [DIM_W-1:0] cfg_dim;

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_dim = DIM_W'(1);
    end else if (32'(cfg_wdata) > MAX_DIM) begin
      cfg_dim = DIM_W'(MAX_DIM);
    end else begin
      cfg_dim = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= RST_DIM;
      col_cnt_r   <= RST_DIM;
      inner_cnt_r <= RST_DIM;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ROW:   row_cnt_r   <= cfg_dim;
        REG_COL:   col_cnt_r   <= cfg_dim;
        REG_INNER: inner_cnt_r <= cfg_dim;
        default:   ;
      endcase
    end
  end

  // input fields
  mode_t                   in_mode;
  logic [IDX_W-1:0]        in_row, in_col;
  logic [ELEM_W-1:0]       in_elem;
  logic                    in_acc;
  logic                    row_ok_rc, col_ok_c, row_ok_k, col_ok_k;
  logic [AW-1:0]           wr_addr, row_base;

  assign in_mode = mode_t'(in_tuser);
  assign in_row  = in_tdata[5:0];
  assign in_col  = in_tdata[11:6];
  assign in_elem = in_tdata[27:12];
  assign in_acc  = in_tvalid && in_tready;

  assign row_ok_rc = {1'b0, in_row} < row_cnt_r;
  assign col_ok_c  = {1'b0, in_col} < col_cnt_r;
  assign row_ok_k  = {1'b0, in_row} < inner_cnt_r;
  assign col_ok_k  = {1'b0, in_col} < inner_cnt_r;

  assign row_base = AW'(in_row) * AW'(MAX_DIM);
  assign wr_addr  = row_base + AW'(in_col);

  // control
  state_t               state_r, state_nxt;
  logic [AW-1:0]        a_addr_r, a_addr_nxt, b_addr_r, b_addr_nxt;
  logic [DIM_W-1:0]     k_r, k_nxt;
  mac_ctl_t             mac_ctl;
  logic                 a_we, b_we;
  logic                 rd_start;
  logic                 imm_load;
  logic                 imm_status;
  logic                 mac_done;
  logic signed [ACC_W-1:0] mac_acc;

  assign in_tready = (state_r == S_IDLE) && (!out_tvalid || out_tready);

  always_comb begin
    state_nxt  = state_r;
    a_addr_nxt = a_addr_r;
    b_addr_nxt = b_addr_r;
    k_nxt      = k_r;
    mac_ctl    = '0;
    a_we       = 1'b0;
    b_we       = 1'b0;
    rd_start   = 1'b0;
    imm_load   = 1'b0;
    imm_status = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_mode)
            MODE_WR_A: begin
              a_we       = row_ok_rc && col_ok_k;
              imm_load   = 1'b1;
              imm_status = !(row_ok_rc && col_ok_k);
            end
            MODE_WR_B: begin
              b_we       = row_ok_k && col_ok_c;
              imm_load   = 1'b1;
              imm_status = !(row_ok_k && col_ok_c);
            end
            MODE_RD: begin
              if (row_ok_rc && col_ok_c) begin
                rd_start = 1'b1;
              end else begin
                imm_load   = 1'b1;
                imm_status = 1'b1;
              end
            end
            default: begin
              imm_load   = 1'b1;
              imm_status = 1'b1;
            end
          endcase
        end
        if (rd_start) begin
          a_addr_nxt = row_base;
          b_addr_nxt = AW'(in_col);
          k_nxt      = '0;
          state_nxt  = S_ISSUE;
        end
      end
      S_ISSUE: begin
        mac_ctl.valid = 1'b1;
        mac_ctl.first = k_r == '0;
        mac_ctl.last  = k_r == inner_cnt_r - DIM_W'(1);
        a_addr_nxt    = a_addr_r + AW'(1);
        b_addr_nxt    = b_addr_r + AW'(MAX_DIM);
        k_nxt         = k_r + DIM_W'(1);
        if (mac_ctl.last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (mac_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_addr_r <= a_addr_nxt;
    b_addr_r <= b_addr_nxt;
    k_r      <= k_nxt;
  end

  // element stores: a write beat uses the port, otherwise the walk addresses
  logic [ELEM_W-1:0] a_rdata, b_rdata;

  mpe_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .addr  (a_we ? wr_addr : a_addr_r),
    .wdata (in_elem),
    .rdata (a_rdata)
  );

  mpe_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .addr  (b_we ? wr_addr : b_addr_r),
    .wdata (in_elem),
    .rdata (b_rdata)
  );

  mpe_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .a_data (a_rdata),
    .b_data (b_rdata),
    .acc    (mac_acc),
    .done   (mac_done)
  );

  // result register
  logic                    out_valid_r;
  logic [ACC_W-1:0]        out_prod_r;
  logic                    out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (imm_load || mac_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_done) begin
      out_prod_r   <= mac_acc;
      out_status_r <= 1'b0;
    end else if (imm_load) begin
      out_prod_r   <= '0;
      out_status_r <= imm_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_prod_r};
  assign out_tuser  = out_status_r;

endmodule

[rtl/mpe_ram.sv]
// generic single-port synchronous ram with registered read
module mpe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/mpe_mac.sv]
// multiply-accumulate pipe fed by the two element stores
module mpe_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mpe_pkg::mac_ctl_t                 ctl,
  input  logic signed [mpe_pkg::ELEM_W-1:0] a_data,
  input  logic signed [mpe_pkg::ELEM_W-1:0] b_data,
  output logic signed [mpe_pkg::ACC_W-1:0]  acc,
  output logic                              done
);
  import mpe_pkg::*;

  mac_ctl_t                 ctl_d1_r;
  mac_ctl_t                 ctl_d2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                     done_r;

  // ctl_d1 lines up with the ram read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d1_r <= '0;
      ctl_d2_r <= '0;
      done_r   <= 1'b0;
    end else begin
      ctl_d1_r <= ctl;
      ctl_d2_r <= ctl_d1_r;
      done_r   <= ctl_d2_r.valid && ctl_d2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_data * b_data;
    if (ctl_d2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  // sum wraps at the accumulator width
  always_comb begin
    if (ctl_d2_r.first) begin
      acc_nxt = ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

[sim/product_checker.sv]
// checker for the matrix product engine: predicts each result beat and compares it
module product_checker
  import mpe_pkg::*;
#(
  parameter int DIM = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // in_tdata: row_index[5:0], col_index[11:6], element_value[27:12], zero pad
  input  logic [31:0]        in_tdata,
  // in_tuser: mode[1:0]
  input  logic [1:0]         in_tuser,
  input  logic               in_tvalid,
  input  logic               in_tready,
  // out_tdata: product_value[37:0], zero pad
  input  logic [39:0]        out_tdata,
  // out_tuser: status[0]
  input  logic               out_tuser,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]   cfg_wdata,
  output int unsigned        fail_count,
  output int unsigned        pending
);

  typedef struct packed {
    logic [ACC_W-1:0] value;
    logic             status;
  } product_beat_t;

  logic signed [ELEM_W-1:0] left_elems  [0:DIM*DIM-1];
  logic signed [ELEM_W-1:0] right_elems [0:DIM*DIM-1];
  int unsigned row_lim, col_lim, inner_lim;
  product_beat_t expected_beats [$];

  initial begin
    fail_count = 0;
    pending = 0;
    for (int i = 0; i < DIM * DIM; i++) begin
      left_elems[i] = '0;
      right_elems[i] = '0;
    end
  end

  // zero counts as one, anything above the store size as the store size
  function automatic int unsigned saturate_dim(input logic [DIM_W-1:0] raw);
    int unsigned v;
    v = raw;
    if (v < 1) v = 1;
    if (v > DIM) v = DIM;
    return v;
  endfunction

  function automatic product_beat_t predict_beat(input logic [1:0] kind,
                                                 input logic [31:0] word);
    int unsigned r;
    int unsigned c;
    logic signed [ELEM_W-1:0] v;
    longint sum;
    product_beat_t res;
    r = word[5:0];
    c = word[11:6];
    v = word[27:12];
    sum = 0;
    res.value = '0;
    res.status = 1'b0;
    case (mode_t'(kind))
      MODE_WR_A: begin
        if (r < row_lim && c < inner_lim) left_elems[r * DIM + c] = v;
        else res.status = 1'b1;
      end
      MODE_WR_B: begin
        if (r < inner_lim && c < col_lim) right_elems[r * DIM + c] = v;
        else res.status = 1'b1;
      end
      MODE_RD: begin
        if (r < row_lim && c < col_lim) begin
          for (int k = 0; k < inner_lim; k++)
            sum += longint'(left_elems[r * DIM + k]) * longint'(right_elems[k * DIM + c]);
          res.value = sum[ACC_W-1:0];
        end else begin
          res.status = 1'b1;
        end
      end
      default: res.status = 1'b1;
    endcase
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input logic [ACC_W-1:0] got,
                               input logic [ACC_W-1:0] want);
    $display("mismatch on %s: got %h, want %h", field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    product_beat_t want;
    if (!rst_n) begin
      row_lim = DIM;
      col_lim = DIM;
      inner_lim = DIM;
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_ROW:   row_lim = saturate_dim(cfg_wdata);
          REG_COL:   col_lim = saturate_dim(cfg_wdata);
          REG_INNER: inner_lim = saturate_dim(cfg_wdata);
          default: ;
        endcase
      end
      // the beat leaving belongs to an older item, so pop before pushing
      if (out_tvalid && out_tready) begin
        if (expected_beats.size() == 0) begin
          flag_mismatch("unexpected beat", out_tdata[ACC_W-1:0], '0);
        end else begin
          want = expected_beats.pop_front();
          if (out_tdata[ACC_W-1:0] !== want.value)
            flag_mismatch("product_value", out_tdata[ACC_W-1:0], want.value);
          if (out_tuser !== want.status)
            flag_mismatch("status", ACC_W'(out_tuser), ACC_W'(want.status));
        end
      end
      if (in_tvalid && in_tready)
        expected_beats.push_back(predict_beat(in_tuser, in_tdata));
    end
    pending = expected_beats.size();
  end

endmodule

[sim/testbench.sv]
// testbench top for the matrix product engine: stimulus, flow control and verdict
module testbench;
  import mpe_pkg::*;

  localparam int DIM = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 166;

  logic               clk;
  logic               rst_n;
  logic [31:0]        in_tdata;
  logic [1:0]         in_tuser;
  logic               in_tvalid;
  logic               in_tready;
  logic [39:0]        out_tdata;
  logic               out_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic               cfg_we;
  logic [CFG_A_W-1:0] cfg_addr;
  logic [DIM_W-1:0]   cfg_wdata;
  int unsigned        fail_count;
  int unsigned        pending;

  int  send_idle_pct;
  int  recv_idle_pct;
  logic quiet;
  int  stretch_cnt;
  int  cycle_count;
  int  eff_rows, eff_cols, eff_inner;
  int  items_sent, reads_sent, settings_used, drains;
  bit  a_written [0:DIM*DIM-1];
  bit  b_written [0:DIM*DIM-1];

  matrix_product_engine_top #(.MAX_DIM(DIM)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  product_checker #(.DIM(DIM)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d beats outstanding", pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // now and then a stretch where neither side holds back
  always @(negedge clk) begin
    stretch_cnt <= stretch_cnt + 1;
    if (stretch_cnt % 64 == 63) quiet <= ($urandom_range(0, 3) == 0);
  end

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= quiet || ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic int clip_dim(input int raw);
    int v;
    v = raw & 127;
    if (v < 1) v = 1;
    if (v > DIM) v = DIM;
    return v;
  endfunction

  // a read may only touch entries that were written
  function automatic bit read_ok(input int r, input int c);
    for (int k = 0; k < eff_inner; k++)
      if (!a_written[r * DIM + k] || !b_written[k * DIM + c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [ELEM_W-1:0] pick_elem();
    case ($urandom_range(0, 15))
      0, 1:    return 16'h8000;
      2, 3:    return 16'h7fff;
      4:       return 16'h0000;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // leaves in_tvalid high at the negedge after the beat is taken
  task automatic send_item(input mode_t m, input int r, input int c,
                           input logic [ELEM_W-1:0] v);
    while (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = m;
    in_tdata = {4'b0, v, c[5:0], r[5:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (m == MODE_WR_A && r < eff_rows && c < eff_inner) a_written[r * DIM + c] = 1'b1;
    if (m == MODE_WR_B && r < eff_inner && c < eff_cols) b_written[r * DIM + c] = 1'b1;
    items_sent++;
    if (m == MODE_RD) reads_sent++;
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    drains++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = DIM_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic enter_setting(input int rows, input int cols, input int inner);
    drain();
    repeat (8) @(negedge clk);
    write_reg(REG_ROW, rows);
    write_reg(REG_COL, cols);
    write_reg(REG_INNER, inner);
    eff_rows = clip_dim(rows);
    eff_cols = clip_dim(cols);
    eff_inner = clip_dim(inner);
    settings_used++;
  endtask

  // fill one row of A and one column of B, then ask for their dot product
  task automatic run_dot_sequence();
    int r;
    int c;
    r = $urandom_range(0, eff_rows - 1);
    c = $urandom_range(0, eff_cols - 1);
    for (int k = 0; k < eff_inner; k++) begin
      if (!a_written[r * DIM + k] || $urandom_range(0, 2) == 0)
        send_item(MODE_WR_A, r, k, pick_elem());
      if (!b_written[k * DIM + c] || $urandom_range(0, 2) == 0)
        send_item(MODE_WR_B, k, c, pick_elem());
    end
    send_item(MODE_RD, r, c, pick_elem());
    if ($urandom_range(0, 9) == 0) drain();
  endtask

  task automatic run_random(input int target);
    int start;
    int pick;
    int r;
    int c;
    mode_t m;
    start = items_sent;
    while (items_sent - start < target) begin
      pick = $urandom_range(0, 99);
      // a full dot sequence only while it still fits in the phase budget
      if (pick < 45 && target - (items_sent - start) > 2 * eff_inner) begin
        run_dot_sequence();
      end else if (pick < 75) begin
        r = $urandom_range(0, eff_rows - 1);
        c = $urandom_range(0, eff_cols - 1);
        if (read_ok(r, c)) send_item(MODE_RD, r, c, pick_elem());
        else if ($urandom_range(0, 1) == 0)
          send_item(MODE_WR_A, r, $urandom_range(0, eff_inner - 1), pick_elem());
        else
          send_item(MODE_WR_B, $urandom_range(0, eff_inner - 1), c, pick_elem());
      end else begin
        // noise: any index and value, any mode but a read of unwritten entries
        m = mode_t'($urandom_range(0, 3));
        r = $urandom_range(0, DIM - 1);
        c = $urandom_range(0, DIM - 1);
        if (m == MODE_RD && r < eff_rows && c < eff_cols && !read_ok(r, c)) m = MODE_NONE;
        send_item(m, r, c, ELEM_W'($urandom));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    quiet = 1'b0;
    stretch_cnt = 0;
    cycle_count = 0;
    items_sent = 0;
    reads_sent = 0;
    settings_used = 0;
    drains = 0;
    eff_rows = DIM;
    eff_cols = DIM;
    eff_inner = DIM;
    send_idle_pct = 9;
    recv_idle_pct = 82;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: saturating register writes, extreme elements, bad indexes
    enter_setting(127, 64, 0);
    send_item(MODE_NONE, 63, 63, 16'hffff);
    send_item(MODE_WR_A, 63, 0, 16'h8000);
    send_item(MODE_WR_B, 0, 63, 16'h8000);
    send_item(MODE_RD, 63, 63, 16'h0000);
    send_item(MODE_WR_A, 0, 0, 16'h7fff);
    send_item(MODE_WR_B, 0, 0, 16'h8000);
    send_item(MODE_RD, 0, 0, 16'hffff);
    send_item(MODE_WR_A, 0, 1, 16'h0001);
    send_item(MODE_WR_B, 1, 0, 16'h0001);
    send_item(MODE_WR_B, 0, 0, 16'h0000);
    send_item(MODE_RD, 0, 0, 16'h0000);
    send_item(MODE_WR_A, 63, 0, 16'h7fff);
    send_item(MODE_WR_B, 0, 63, 16'h7fff);
    send_item(MODE_RD, 63, 63, 16'h0000);
    send_item(MODE_NONE, 0, 0, 16'h0000);
    // shrink to one element: stores survive, everything else is out of range
    enter_setting(1, 1, 1);
    send_item(MODE_RD, 1, 0, 16'h0000);
    send_item(MODE_RD, 0, 1, 16'h0000);
    send_item(MODE_WR_A, 1, 0, 16'h1234);
    send_item(MODE_WR_B, 0, 1, 16'h1234);
    send_item(MODE_RD, 0, 0, 16'h0000);

    enter_setting(5, 4, 8);
    run_random(PHASE_ITEMS);

    send_idle_pct = 82;
    recv_idle_pct = 9;
    enter_setting(1, 64, 64);
    run_random(PHASE_ITEMS);
    enter_setting(64, 1, 2);
    run_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    enter_setting(3, 100, 16);
    run_random(PHASE_ITEMS);
    enter_setting(64, 64, 64);
    run_random(PHASE_ITEMS);

    drain();
    repeat (80) @(negedge clk);
    $display("covered %0d beats, %0d of them product reads, over %0d dimension settings",
             items_sent, reads_sent, settings_used);
    $display("sender paused for a full drain %0d times", drains);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
